// ----- hdl/tlg_pkg.sv -----
package tlg_pkg;

    // Grid store limits and derived index widths
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Grid size registers are 7 bits wide, smallest legal torus is 3
    localparam int SIZE_W = 7;
    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

    // Commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_THR    = 3'd4;

    // RGB565 full-intensity channel masks
    localparam logic [15:0] RED_MASK   = 16'hF800;
    localparam logic [15:0] GREEN_MASK = 16'h07E0;
    localparam logic [15:0] BLUE_MASK  = 16'h001F;

    // One grid row: plane 0 red, plane 1 green, plane 2 blue
    typedef logic [2:0][MAX_WIDTH-1:0] plane_row_t;

    // Operation broadcast to every row cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_WRITE,
        CELL_LOAD,
        CELL_CAPTURE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [SIZE_W-1:0] height;
        logic [2:0]        bits;
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ_LOAD,
        ST_READ_SHIFT,
        ST_STEP_RUN,
        ST_STEP_FIX,
        ST_RESULT
    } state_t;

    // Clamp a grid size register into [MIN_SIZE, hi]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < MIN_SIZE)
        begin
            r = MIN_SIZE;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ----- hdl/toroidal_life_grid_rgb_top.sv -----
// Throughput: one item at a time; a step sweeps the row-cell ring one row per cycle,
// so the rate is set by the grid height (up to 64 rows plus a wrap fix-up state).
// A new item is accepted while the previous result waits in the output register.
// Reset: all cells dead at once (flip-flop store, no clearing pass), registers
// return to width 64, height 64, thresholds 8/16/8.
module toroidal_life_grid_rgb_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlg_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       command,
    input  logic [5:0]                       column,
    input  logic [5:0]                       row,
    input  logic [15:0]                      pixel_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      pixel_out,
    output logic                             coordinate_error
);

    // Configuration registers
    logic [tlg_pkg::SIZE_W-1:0] grid_width_reg;
    logic [tlg_pkg::SIZE_W-1:0] grid_height_reg;
    logic [4:0]                 red_thr_reg;
    logic [5:0]                 green_thr_reg;
    logic [4:0]                 blue_thr_reg;
    logic [tlg_pkg::SIZE_W-1:0] w_eff;
    logic [tlg_pkg::SIZE_W-1:0] h_eff;

    // Sequencer and item registers
    tlg_pkg::state_t            state_reg;
    tlg_pkg::state_t            state_next;
    logic [tlg_pkg::ROW_W-1:0]  cnt_reg;
    logic [tlg_pkg::ROW_W-1:0]  cnt_next;
    logic [tlg_pkg::COL_W-1:0]  sel_col_reg;
    logic [tlg_pkg::ROW_W-1:0]  sel_row_reg;
    logic [15:0]                pix_reg;
    logic                       err_reg;
    logic [15:0]                res_pix_reg;
    tlg_pkg::plane_row_t        prev_row_reg;
    tlg_pkg::plane_row_t        orig0_reg;
    tlg_pkg::plane_row_t        orig1_reg;

    // Output register
    logic                       out_valid_reg;
    logic [15:0]                pixel_out_reg;
    logic                       err_out_reg;

    // Datapath nets
    logic                       in_fire;
    logic                       coord_bad;
    logic                       out_free;
    logic                       load_out;
    logic                       last_row;
    logic [2:0]                 write_bits;
    tlg_pkg::cell_ctrl_t        ctrl;
    tlg_pkg::plane_row_t        bcast_row;
    tlg_pkg::plane_row_t        rule_down;
    tlg_pkg::plane_row_t        rule_out;
    tlg_pkg::plane_row_t        cell_rows  [tlg_pkg::MAX_HEIGHT];
    logic [2:0]                 cell_carry [tlg_pkg::MAX_HEIGHT];
    logic [15:0]                read_colour;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= tlg_pkg::SIZE_W'(64);
            grid_height_reg <= tlg_pkg::SIZE_W'(64);
            red_thr_reg     <= 5'd8;
            green_thr_reg   <= 6'd16;
            blue_thr_reg    <= 5'd8;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tlg_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                tlg_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                tlg_pkg::REG_RED_THR:     red_thr_reg     <= cfg_data[4:0];
                tlg_pkg::REG_GREEN_THR:   green_thr_reg   <= cfg_data[5:0];
                tlg_pkg::REG_BLUE_THR:    blue_thr_reg    <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    assign w_eff = tlg_pkg::clamp_size(grid_width_reg,
                                       tlg_pkg::SIZE_W'(tlg_pkg::MAX_WIDTH));
    assign h_eff = tlg_pkg::clamp_size(grid_height_reg,
                                       tlg_pkg::SIZE_W'(tlg_pkg::MAX_HEIGHT));

    // Handshake helpers
    assign in_fire   = in_valid && in_ready;
    assign coord_bad = (tlg_pkg::SIZE_W'(column) >= w_eff) || (tlg_pkg::SIZE_W'(row) >= h_eff);
    assign out_free  = !out_valid_reg || out_ready;
    assign last_row  = (tlg_pkg::SIZE_W'(cnt_reg) + tlg_pkg::SIZE_W'(1)) == h_eff;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlg_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (command)
                        tlg_pkg::CMD_WRITE:
                            state_next = coord_bad ? tlg_pkg::ST_RESULT : tlg_pkg::ST_WRITE;
                        tlg_pkg::CMD_READ:
                            state_next = coord_bad ? tlg_pkg::ST_RESULT
                                                   : tlg_pkg::ST_READ_LOAD;
                        tlg_pkg::CMD_STEP:
                            state_next = tlg_pkg::ST_STEP_RUN;
                        default:
                            state_next = tlg_pkg::ST_RESULT;
                    endcase
                end
            end
            tlg_pkg::ST_WRITE:
                state_next = tlg_pkg::ST_RESULT;
            tlg_pkg::ST_READ_LOAD:
                state_next = tlg_pkg::ST_READ_SHIFT;
            tlg_pkg::ST_READ_SHIFT:
            begin
                if (cnt_reg == sel_row_reg)
                begin
                    state_next = tlg_pkg::ST_RESULT;
                end
            end
            tlg_pkg::ST_STEP_RUN:
            begin
                if (last_row)
                begin
                    state_next = tlg_pkg::ST_STEP_FIX;
                end
            end
            tlg_pkg::ST_STEP_FIX:
                state_next = tlg_pkg::ST_RESULT;
            tlg_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = tlg_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tlg_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        load_out    = 1'b0;
        ctrl.op     = tlg_pkg::CELL_HOLD;
        ctrl.column = sel_col_reg;
        ctrl.row    = sel_row_reg;
        ctrl.height = h_eff;
        ctrl.bits   = write_bits;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            tlg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
            end
            tlg_pkg::ST_WRITE:
                ctrl.op = tlg_pkg::CELL_WRITE;
            tlg_pkg::ST_READ_LOAD:
                ctrl.op = tlg_pkg::CELL_CAPTURE;
            tlg_pkg::ST_READ_SHIFT:
                cnt_next = cnt_reg + tlg_pkg::ROW_W'(1);
            tlg_pkg::ST_STEP_RUN:
            begin
                ctrl.op  = tlg_pkg::CELL_SHIFT;
                cnt_next = cnt_reg + tlg_pkg::ROW_W'(1);
            end
            tlg_pkg::ST_STEP_FIX:
            begin
                ctrl.op  = tlg_pkg::CELL_LOAD;
                ctrl.row = '0;
            end
            tlg_pkg::ST_RESULT:
                load_out = out_free;
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pixel thresholding for writes
    assign write_bits = {pix_reg[4:0] > blue_thr_reg,
                         pix_reg[10:5] > green_thr_reg,
                         pix_reg[15:11] > red_thr_reg};

    // Cell colour arriving at the head of the read carry chain
    assign read_colour = (cell_carry[0][0] ? tlg_pkg::RED_MASK   : 16'h0000)
                       | (cell_carry[0][1] ? tlg_pkg::GREEN_MASK : 16'h0000)
                       | (cell_carry[0][2] ? tlg_pkg::BLUE_MASK  : 16'h0000);

    // Generation sweep: neighbour rows for the row leaving cell 0
    assign rule_down = (state_reg == tlg_pkg::ST_STEP_FIX) ? orig1_reg
                     : (last_row ? orig0_reg : cell_rows[1]);

    // Row 0 passes through untouched on the first shift and is fixed afterwards
    assign bcast_row = ((state_reg == tlg_pkg::ST_STEP_RUN) && (cnt_reg == '0)) ? cell_rows[0]
                                                                                : rule_out;

    tlg_row_rule u_rule (
        .up       (prev_row_reg),
        .mid      (cell_rows[0]),
        .down     (rule_down),
        .width    (w_eff),
        .next_row (rule_out)
    );

    // Item and sweep payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sel_col_reg <= column;
            sel_row_reg <= row;
            pix_reg     <= pixel_in;
            err_reg     <= ((command == tlg_pkg::CMD_WRITE) || (command == tlg_pkg::CMD_READ))
                           && coord_bad;
            res_pix_reg <= 16'h0000;
        end
        if ((state_reg == tlg_pkg::ST_READ_SHIFT) && (cnt_reg == sel_row_reg))
        begin
            res_pix_reg <= read_colour;
        end
        if (state_reg == tlg_pkg::ST_STEP_RUN)
        begin
            prev_row_reg <= cell_rows[0];
            if (cnt_reg == '0)
            begin
                orig0_reg <= cell_rows[0];
                orig1_reg <= cell_rows[1];
            end
        end
        if (load_out)
        begin
            pixel_out_reg <= res_pix_reg;
            err_out_reg   <= err_reg;
        end
    end

    // Ring of row cells: each takes its neighbour's row on a shift, the tail the broadcast row
    for (genvar i = 0; i < tlg_pkg::MAX_HEIGHT; i++)
    begin : g_cell
        tlg_pkg::plane_row_t nb_row;
        logic [2:0]          nb_carry;

        if (i == tlg_pkg::MAX_HEIGHT - 1)
        begin : g_end
            assign nb_row   = '0;
            assign nb_carry = '0;
        end
        else
        begin : g_mid
            assign nb_row   = cell_rows[i+1];
            assign nb_carry = cell_carry[i+1];
        end

        tlg_row_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (tlg_pkg::ROW_W'(i)),
            .ctrl       (ctrl),
            .bcast_row  (bcast_row),
            .next_row   (nb_row),
            .next_carry (nb_carry),
            .row_out    (cell_rows[i]),
            .carry_out  (cell_carry[i])
        );
    end

    assign out_valid        = out_valid_reg;
    assign pixel_out        = pixel_out_reg;
    assign coordinate_error = err_out_reg;

`ifndef SYNTHESIS
    a_step_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (command == tlg_pkg::CMD_STEP)) |=> (state_reg == tlg_pkg::ST_STEP_RUN))
        else $error("step command did not start a sweep");

    a_sweep_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlg_pkg::ST_STEP_RUN) |-> (tlg_pkg::SIZE_W'(cnt_reg) < h_eff))
        else $error("sweep row counter ran past the grid height");

    a_read_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlg_pkg::ST_READ_SHIFT) |-> (cnt_reg <= sel_row_reg))
        else $error("read carry shift overran the target row");

    a_error_has_no_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_out_reg) |-> (pixel_out_reg == 16'h0000))
        else $error("coordinate error beat carries a colour");
`endif

endmodule

// ----- hdl/tlg_row_rule.sv -----
module tlg_row_rule (
    input  tlg_pkg::plane_row_t              up,
    input  tlg_pkg::plane_row_t              mid,
    input  tlg_pkg::plane_row_t              down,
    input  logic [tlg_pkg::SIZE_W-1:0]       width,
    output tlg_pkg::plane_row_t              next_row
);

    // Vertical 3-cell sums per column, then horizontal sum with wrap at width
    logic [2:0][tlg_pkg::MAX_WIDTH-1:0][1:0] vsum;
    logic [tlg_pkg::COL_W-1:0]               last_col;

    assign last_col = tlg_pkg::COL_W'(width - tlg_pkg::SIZE_W'(1));

    for (genvar p = 0; p < 3; p++)
    begin : g_plane
        for (genvar x = 0; x < tlg_pkg::MAX_WIDTH; x++)
        begin : g_col
            logic [1:0] left_sum;
            logic [1:0] right_sum;
            logic [3:0] box_sum;
            logic       in_grid;

            assign vsum[p][x] = 2'(up[p][x]) + 2'(mid[p][x]) + 2'(down[p][x]);

            if (x == 0)
            begin : g_left_wrap
                assign left_sum = vsum[p][last_col];
            end
            else
            begin : g_left
                assign left_sum = vsum[p][x-1];
            end

            if (x == tlg_pkg::MAX_WIDTH - 1)
            begin : g_right_wrap
                assign right_sum = vsum[p][0];
            end
            else
            begin : g_right
                assign right_sum = (width == tlg_pkg::SIZE_W'(x + 1)) ? vsum[p][0]
                                                                       : vsum[p][x+1];
            end

            assign box_sum = 4'(left_sum) + 4'(vsum[p][x]) + 4'(right_sum);
            assign in_grid = tlg_pkg::SIZE_W'(x) < width;

            // B3/S23 on the box sum; columns beyond the torus keep their value
            assign next_row[p][x] = !in_grid ? mid[p][x]
                                  : ((box_sum == 4'd3) || ((box_sum == 4'd4) && mid[p][x]));
        end
    end

endmodule

// ----- hdl/tlg_row_cell.sv -----
module tlg_row_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tlg_pkg::ROW_W-1:0]   cell_index,
    input  tlg_pkg::cell_ctrl_t         ctrl,
    input  tlg_pkg::plane_row_t         bcast_row,
    input  tlg_pkg::plane_row_t         next_row,
    input  logic [2:0]                  next_carry,
    output tlg_pkg::plane_row_t         row_out,
    output logic [2:0]                  carry_out
);

    tlg_pkg::plane_row_t row_reg;
    tlg_pkg::plane_row_t row_next;
    logic [2:0]          carry_reg;
    logic [2:0]          carry_next;
    logic                active;
    logic                is_tail;
    logic                hit;

    // Position of this cell relative to the active torus
    assign active  = tlg_pkg::SIZE_W'(cell_index) < ctrl.height;
    assign is_tail = (tlg_pkg::SIZE_W'(cell_index) + tlg_pkg::SIZE_W'(1)) == ctrl.height;
    assign hit     = cell_index == ctrl.row;

    // Row update
    always_comb
    begin
        row_next = row_reg;
        unique case (ctrl.op)
            tlg_pkg::CELL_SHIFT:
            begin
                if (active)
                begin
                    row_next = is_tail ? bcast_row : next_row;
                end
            end
            tlg_pkg::CELL_WRITE:
            begin
                if (hit)
                begin
                    for (int p = 0; p < 3; p++)
                    begin
                        row_next[p][ctrl.column] = ctrl.bits[p];
                    end
                end
            end
            tlg_pkg::CELL_LOAD:
            begin
                if (hit)
                begin
                    row_next = bcast_row;
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // Read carry: capture own column, otherwise pass the neighbour's towards cell 0
    always_comb
    begin
        if (ctrl.op == tlg_pkg::CELL_CAPTURE)
        begin
            carry_next = {row_reg[2][ctrl.column], row_reg[1][ctrl.column],
                          row_reg[0][ctrl.column]};
        end
        else
        begin
            carry_next = next_carry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign row_out   = row_reg;
    assign carry_out = carry_reg;

endmodule

// ----- tb/life_grid_monitor.sv -----
module life_grid_monitor
    import tlg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           command,
    input  logic [5:0]           column,
    input  logic [5:0]           row,
    input  logic [15:0]          pixel_in,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [15:0]          pixel_out,
    input  logic                 coordinate_error,
    output int                   failures,
    output int                   results_seen
);

    typedef struct packed {
        logic [15:0] pixel;
        logic        err;
    } cell_reply_t;

    // Shadow of the cell store, plane bits as in the block: 0 red, 1 green, 2 blue
    logic [2:0]        cells      [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [2:0]        next_cells [0:MAX_WIDTH*MAX_HEIGHT-1];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [4:0]        red_thr;
    logic [5:0]        green_thr;
    logic [4:0]        blue_thr;

    cell_reply_t expected_replies[$];
    int          mismatch_count;
    int          pending;

    // Anything still owed at the end counts against the run
    assign failures = mismatch_count + pending;

    function automatic int fit_size(input logic [SIZE_W-1:0] v, input int hi);
        int r;
        r = int'(v);
        if (r < 3)
        begin
            r = 3;
        end
        else if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // One B3/S23 generation on each plane, 3x3 box sum including the cell itself
    task automatic advance_generation(input int w, input int h);
        int         xs[3];
        int         ys[3];
        int         sum;
        logic [2:0] nv;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                xs[0] = (x == 0) ? w - 1 : x - 1;
                xs[1] = x;
                xs[2] = (x + 1 == w) ? 0 : x + 1;
                ys[0] = (y == 0) ? h - 1 : y - 1;
                ys[1] = y;
                ys[2] = (y + 1 == h) ? 0 : y + 1;
                nv = '0;
                for (int p = 0; p < 3; p++)
                begin
                    sum = 0;
                    for (int dy = 0; dy < 3; dy++)
                    begin
                        for (int dx = 0; dx < 3; dx++)
                        begin
                            sum += int'(cells[ys[dy]*MAX_WIDTH + xs[dx]][p]);
                        end
                    end
                    if (sum == 3 || (sum == 4 && cells[y*MAX_WIDTH + x][p]))
                    begin
                        nv[p] = 1'b1;
                    end
                end
                next_cells[y*MAX_WIDTH + x] = nv;
            end
        end
        // cells beyond the active area are left alone
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                cells[y*MAX_WIDTH + x] = next_cells[y*MAX_WIDTH + x];
            end
        end
    endtask

    // Update the shadow store for one command and work out its reply
    task automatic apply_command(input logic [1:0] cmd, input logic [5:0] col,
                                 input logic [5:0] r, input logic [15:0] pix,
                                 output cell_reply_t reply);
        int         w;
        int         h;
        int         idx;
        logic [2:0] alive;
        w     = fit_size(width_reg, MAX_WIDTH);
        h     = fit_size(height_reg, MAX_HEIGHT);
        reply = '0;
        if (cmd == CMD_STEP)
        begin
            advance_generation(w, h);
        end
        else if (cmd == CMD_WRITE || cmd == CMD_READ)
        begin
            if (col >= w || r >= h)
            begin
                reply.err = 1'b1;
            end
            else
            begin
                idx = r*MAX_WIDTH + col;
                if (cmd == CMD_WRITE)
                begin
                    alive[0]   = pix[15:11] > red_thr;
                    alive[1]   = pix[10:5] > green_thr;
                    alive[2]   = pix[4:0] > blue_thr;
                    cells[idx] = alive;
                end
                else
                begin
                    if (cells[idx][0]) reply.pixel |= RED_MASK;
                    if (cells[idx][1]) reply.pixel |= GREEN_MASK;
                    if (cells[idx][2]) reply.pixel |= BLUE_MASK;
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
        end
    endtask

    // Watch config writes and both channels; one beat each way per edge at most
    always @(posedge clk or negedge rst_n)
    begin
        cell_reply_t reply;
        cell_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++)
            begin
                cells[i] = '0;
            end
            width_reg  = SIZE_W'(64);
            height_reg = SIZE_W'(64);
            red_thr    = 5'd8;
            green_thr  = 6'd16;
            blue_thr   = 5'd8;
            expected_replies.delete();
            pending        = 0;
            mismatch_count = 0;
            results_seen   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:  width_reg  = cfg_data;
                    REG_GRID_HEIGHT: height_reg = cfg_data;
                    REG_RED_THR:     red_thr    = cfg_data[4:0];
                    REG_GREEN_THR:   green_thr  = cfg_data[5:0];
                    REG_BLUE_THR:    blue_thr   = cfg_data[4:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                apply_command(command, column, row, pixel_in, reply);
                expected_replies.push_back(reply);
            end

            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_replies.size() == 0)
                begin
                    note_mismatch("unexpected result beat, pixel_out", 16'h0000, pixel_out);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (pixel_out !== want.pixel)
                    begin
                        note_mismatch("pixel_out", want.pixel, pixel_out);
                    end
                    if (coordinate_error !== want.err)
                    begin
                        note_mismatch("coordinate_error", 16'(want.err),
                                      16'(coordinate_error));
                    end
                end
            end
            pending = expected_replies.size();
        end
    end

endmodule

// ----- tb/toroidal_life_grid_rgb_top_tb.sv -----
module toroidal_life_grid_rgb_top_tb;

    import tlg_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         TIMEOUT     = 4_000_000;
    localparam int         PHASE_ITEMS = 70;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           command;
    logic [5:0]           column;
    logic [5:0]           row;
    logic [15:0]          pixel_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [15:0]          pixel_out;
    logic                 coordinate_error;

    int failures;
    int results_seen;
    int items_sent;
    int cur_w;
    int cur_h;
    bit steady;

    // Grid sizes and thresholds per phase: width, height, red, green, blue
    int phase_cfg[7][5] = '{
        '{3,   3,  0,  0,  0},
        '{0,   2, 31, 63, 31},
        '{5,   7,  8, 16,  8},
        '{127, 64, 15, 31, 15},
        '{64,  1,  4, 40, 20},
        '{17, 11,  0, 63,  0},
        '{64, 64,  8, 16,  8}
    };

    toroidal_life_grid_rgb_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .column           (column),
        .row              (row),
        .pixel_in         (pixel_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pixel_out        (pixel_out),
        .coordinate_error (coordinate_error)
    );

    life_grid_monitor grid_watch (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .column           (column),
        .row              (row),
        .pixel_in         (pixel_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pixel_out        (pixel_out),
        .coordinate_error (coordinate_error),
        .failures         (failures),
        .results_seen     (results_seen)
    );

    // 10-unit clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #TIMEOUT;
        $display("status: fail");
        $finish;
    end

    // Result side: random stall before each beat unless running steady
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One command beat, with a random gap in front unless running steady
    task automatic send_item(input logic [1:0] cmd, input logic [5:0] col,
                             input logic [5:0] r, input logic [15:0] pix);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        column   <= col;
        row      <= r;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Hold off until every result beat is back
    task automatic drain();
        in_valid <= 1'b0;
        while (results_seen < items_sent) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= SIZE_W'(val);
        @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h, input int rt, input int gt,
                            input int bt);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_RED_THR, rt);
        write_reg(REG_GREEN_THR, gt);
        write_reg(REG_BLUE_THR, bt);
        cfg_write <= 1'b0;
        cur_w = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_h = (h < 3) ? 3 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endtask

    // Mostly in-grid writes and reads near the wrap edges, with steps between;
    // the rest is off-grid coordinates, the unused command and plain noise
    task automatic random_item();
        int          sel;
        logic [1:0]  cmd;
        logic [5:0]  c;
        logic [5:0]  r;
        logic [15:0] pix;
        sel = $urandom_range(0, 99);
        pix = 16'($urandom_range(0, 65535));
        c   = 6'((cur_w > 12) ? ($urandom_range(0, 1) ? $urandom_range(0, 5)
                                                      : cur_w - 1 - $urandom_range(0, 5))
                              : $urandom_range(0, cur_w - 1));
        r   = 6'((cur_h > 12) ? ($urandom_range(0, 1) ? $urandom_range(0, 5)
                                                      : cur_h - 1 - $urandom_range(0, 5))
                              : $urandom_range(0, cur_h - 1));
        if (sel < 40)
        begin
            cmd = CMD_WRITE;
        end
        else if (sel < 68)
        begin
            cmd = CMD_READ;
        end
        else if (sel < 82)
        begin
            cmd = CMD_STEP;
            c   = 6'($urandom_range(0, 63));
            r   = 6'($urandom_range(0, 63));
        end
        else if (sel < 92)
        begin
            cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            if (cur_w < MAX_WIDTH && ($urandom_range(0, 1) || cur_h == MAX_HEIGHT))
            begin
                c = 6'($urandom_range(cur_w, 63));
            end
            else if (cur_h < MAX_HEIGHT)
            begin
                r = 6'($urandom_range(cur_h, 63));
            end
        end
        else if (sel < 97)
        begin
            cmd = CMD_UNUSED;
            c   = 6'($urandom_range(0, 63));
            r   = 6'($urandom_range(0, 63));
        end
        else
        begin
            cmd = 2'($urandom_range(0, 3));
            c   = 6'($urandom_range(0, 63));
            r   = 6'($urandom_range(0, 63));
        end
        send_item(cmd, c, r, pix);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        command    <= CMD_WRITE;
        column     <= '0;
        row        <= '0;
        pixel_in   <= '0;
        steady     = 1'b0;
        items_sent = 0;
        cur_w      = MAX_WIDTH;
        cur_h      = MAX_HEIGHT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset grid, corners, threshold edges, single planes
        send_item(CMD_WRITE, 6'd0, 6'd0, 16'hFFFF);
        send_item(CMD_WRITE, 6'd63, 6'd63, 16'h0000);
        send_item(CMD_WRITE, 6'd1, 6'd0, 16'h4208);
        send_item(CMD_WRITE, 6'd2, 6'd0, 16'h4A29);
        send_item(CMD_READ, 6'd0, 6'd0, 16'h0000);
        send_item(CMD_READ, 6'd1, 6'd0, 16'hFFFF);
        send_item(CMD_READ, 6'd2, 6'd0, 16'h0000);
        send_item(CMD_READ, 6'd63, 6'd63, 16'h0000);
        send_item(CMD_WRITE, 6'd63, 6'd5, 16'hF800);
        send_item(CMD_WRITE, 6'd0, 6'd5, 16'h07E0);
        send_item(CMD_READ, 6'd63, 6'd5, 16'h0000);
        send_item(CMD_READ, 6'd0, 6'd5, 16'h0000);
        // blinker lying across the horizontal wrap
        send_item(CMD_WRITE, 6'd63, 6'd10, 16'hFFFF);
        send_item(CMD_WRITE, 6'd0, 6'd10, 16'hFFFF);
        send_item(CMD_WRITE, 6'd1, 6'd10, 16'hFFFF);
        send_item(CMD_STEP, 6'd63, 6'd63, 16'hFFFF);
        send_item(CMD_READ, 6'd0, 6'd9, 16'h0000);
        send_item(CMD_READ, 6'd0, 6'd11, 16'h0000);
        send_item(CMD_READ, 6'd63, 6'd10, 16'h0000);
        send_item(CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF);
        send_item(CMD_STEP, 6'd0, 6'd0, 16'h0000);
        send_item(CMD_READ, 6'd0, 6'd10, 16'h0000);
        drain();

        // Random phases, each under its own grid size and thresholds
        for (int ph = 0; ph < 7; ph++)
        begin
            set_grid(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2],
                     phase_cfg[ph][3], phase_cfg[ph][4]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    steady = !steady;
                end
                random_item();
            end
            drain();
        end

        repeat (70) @(posedge clk);
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
